// File: rtl/asbpt_pkg.sv
// package for the adc spike blanker and peak tracker
// shared widths, register indexes, defaults and the configuration struct
// no dependencies
package asbpt_pkg;

    localparam int CODE_W      = 24;
    localparam int PEAK_W      = 23;
    localparam int NUM_CHAN    = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam int RING_DEPTH_DEF    = 64;
    localparam int CHANNEL_COUNT_DEF = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MASK     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE_ENABLE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLANK_ENABLE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPIKE_SHIFT      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLANK_LENGTH     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PRE_TRIGGER_LEN  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_WINDOW      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_ATTENUATION = 3'd7;

    typedef struct packed {
        logic [2:0]  channel_mask;
        logic        capture_enable;
        logic        blank_enable;
        logic [3:0]  spike_shift;
        logic [15:0] blank_length;
        logic [5:0]  pre_trigger_length;
        logic [14:0] peak_window;
        logic [4:0]  peak_attenuation;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        channel_mask:       3'd1,
        capture_enable:     1'b0,
        blank_enable:       1'b0,
        spike_shift:        4'd2,
        blank_length:       16'd0,
        pre_trigger_length: 6'd0,
        peak_window:        15'd1024,
        peak_attenuation:   5'd3
    };

endpackage

// File: rtl/adc_spike_blanker_peak_tracker.sv
// top level of the adc spike blanker and peak tracker
// depends on asbpt_pkg, asbpt_cfg, asbpt_blank, asbpt_peak
//
// s_* is the frame input: one transaction carries three raw 24-bit codes.
// m_* is the result output: packed channels, slot count and tracked peak.
// cfg_* writes one register per transaction, index as listed in asbpt_pkg;
// cfg_ready is always high, writes are meant to happen while the block is idle.
// a frame is taken into an input register, processed combinationally against the
// blanking and peak state, and the result lands in an output register.
// throughput is one frame per cycle while the output is not stalled, set by the
// single read-modify-write of the delay memory whose read port prefetches the
// entry at the next ring head.
// frames are dropped with no result when capture is off, the mask selects no
// channel, or the first selected channel is blanked or held in the delay ring.
// when m_tready is low the result holds and one more frame may wait in the
// input register; s_tready then falls until the result is taken.
// reset clears all control state; the data registers and the delay memory are not
// cleared, only written entries are ever read.
module adc_spike_blanker_peak_tracker
    import asbpt_pkg::*;
#(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [71:0]            s_tdata,   // chan0_code, chan1_code, chan2_code
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [103:0]           m_tdata,   // slot_a, slot_b, slot_c, slot_count, peak_level
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [NUM_CHAN-1:0] CHAN_EN = NUM_CHAN'((1 << CHANNEL_COUNT) - 1);

    cfg_t cfg;

    logic              in_valid_reg;
    logic [71:0]       in_data_reg;
    logic              out_valid_reg;
    logic [103:0]      out_data_reg;

    logic              out_free;
    logic              advance;
    logic              proc;
    logic              blank_step;
    logic              emit;
    logic [NUM_CHAN-1:0] mask;
    logic [NUM_CHAN-1:0][CODE_W-1:0] slot;
    logic [1:0]        cnt;
    logic              release_ok;
    logic signed [CODE_W-1:0] release_sample;
    logic signed [CODE_W-1:0] slot_a;
    logic [PEAK_W-1:0] peak;
    logic [PEAK_W-1:0] peak_next;

    asbpt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign mask     = cfg.channel_mask & CHAN_EN;

    // pack selected channels in ascending order
    always_comb
    begin
        slot = '0;
        cnt  = 2'd0;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            if (mask[i])
            begin
                slot[cnt] = in_data_reg[i*CODE_W +: CODE_W];
                cnt       = cnt + 1'b1;
            end
        end
    end

    assign proc       = advance && cfg.capture_enable && (cnt != 2'd0);
    assign blank_step = proc && cfg.blank_enable;
    assign emit       = proc && (!cfg.blank_enable || release_ok);
    assign slot_a     = cfg.blank_enable ? release_sample : $signed(slot[0]);

    asbpt_blank #(
        .RING_DEPTH (RING_DEPTH)
    ) u_blank (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .step           (blank_step),
        .sample         ($signed(slot[0])),
        .running_peak   (peak),
        .release_ok     (release_ok),
        .release_sample (release_sample)
    );

    asbpt_peak u_peak (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (emit),
        .sample    (slot_a),
        .peak      (peak),
        .peak_next (peak_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
        if (emit)
        begin
            out_data_reg <= {7'd0, peak_next, cnt, slot[2], slot[1], slot_a};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/asbpt_cfg.sv
// configuration register file
// depends on asbpt_pkg
module asbpt_cfg
    import asbpt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHANNEL_MASK:     cfg_reg.channel_mask       <= cfg_data[2:0];
                REG_CAPTURE_ENABLE:   cfg_reg.capture_enable     <= cfg_data[0];
                REG_BLANK_ENABLE:     cfg_reg.blank_enable       <= cfg_data[0];
                REG_SPIKE_SHIFT:      cfg_reg.spike_shift        <= cfg_data[3:0];
                REG_BLANK_LENGTH:     cfg_reg.blank_length       <= cfg_data[15:0];
                REG_PRE_TRIGGER_LEN:  cfg_reg.pre_trigger_length <= cfg_data[5:0];
                REG_PEAK_WINDOW:      cfg_reg.peak_window        <= cfg_data[14:0];
                REG_PEAK_ATTENUATION: cfg_reg.peak_attenuation   <= cfg_data[4:0];
                default:              cfg_reg                    <= cfg_reg;
            endcase
        end
    end

endmodule

// File: rtl/asbpt_ring.sv
// pre-trigger delay memory, one write port and one prefetching read port
// read data is registered, a same-cycle write to the read address is bypassed
// depends on asbpt_pkg
module asbpt_ring
    import asbpt_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CODE_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [CODE_W-1:0] rd_data
);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] rd_data_reg;
    logic [CODE_W-1:0] byp_data_reg;
    logic              byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_data_reg;

endmodule

// File: rtl/asbpt_blank.sv
// spike detection, hold-off counter and pre-trigger delay control
// depends on asbpt_pkg and asbpt_ring
module asbpt_blank
    import asbpt_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     step,
    input  logic signed [CODE_W-1:0] sample,
    input  logic [PEAK_W-1:0]        running_peak,
    output logic                     release_ok,
    output logic signed [CODE_W-1:0] release_sample
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int CW = (FW > 6) ? FW : 6;
    localparam int TW = PEAK_W + 15;

    logic [AW-1:0]  head_reg, head_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [15:0]    holdoff_reg, holdoff_next;

    logic [CW-1:0]  pre_ext;
    logic [FW-1:0]  pre_sat;
    logic [FW:0]    need;
    logic [TW-1:0]  threshold;
    logic           spike;
    logic [AW:0]    fill_sum;
    logic [AW-1:0]  fill_addr;
    logic [AW-1:0]  head_inc;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [CODE_W-1:0] rd_data;

    assign pre_ext   = CW'(cfg.pre_trigger_length);
    assign pre_sat   = (pre_ext > CW'(RING_DEPTH)) ? FW'(RING_DEPTH) : FW'(pre_ext);
    assign need      = (FW+1)'(pre_sat) + 1'b1;
    assign threshold = TW'(running_peak) << cfg.spike_shift;
    assign spike     = !sample[CODE_W-1] && (TW'(sample[CODE_W-2:0]) > threshold);
    assign fill_sum  = (AW+1)'(head_reg) + (AW+1)'(fill_reg);
    assign fill_addr = (fill_sum >= (AW+1)'(RING_DEPTH))
                       ? AW'(fill_sum - (AW+1)'(RING_DEPTH)) : AW'(fill_sum);
    assign head_inc  = (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        holdoff_next   = holdoff_reg;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        release_ok     = 1'b0;
        release_sample = sample;
        if (step)
        begin
            if (holdoff_reg != 16'd0)
            begin
                holdoff_next = holdoff_reg - 1'b1;
            end
            else if (spike)
            begin
                holdoff_next = ({1'b0, cfg.blank_length} > 17'(need))
                               ? 16'(17'(cfg.blank_length) - 17'(need)) : 16'd0;
                fill_next    = '0;
            end
            else if (fill_reg < pre_sat)
            begin
                wr_en     = 1'b1;
                wr_addr   = fill_addr;
                fill_next = fill_reg + 1'b1;
            end
            else if (fill_reg == '0)
            begin
                release_ok = 1'b1;
            end
            else
            begin
                release_ok     = 1'b1;
                release_sample = rd_data;
                wr_en          = 1'b1;
                wr_addr        = head_reg;
                head_next      = head_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            fill_reg    <= '0;
            holdoff_reg <= '0;
        end
        else
        begin
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            holdoff_reg <= holdoff_next;
        end
    end

    asbpt_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sample),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(RING_DEPTH))
        else $error("ring fill above depth");

    a_holdoff_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        step && (holdoff_reg != 16'd0) |-> !release_ok)
        else $error("sample released during hold-off");

    a_spike_empties: assert property (@(posedge clk) disable iff (!rst_n)
        step && (holdoff_reg == 16'd0) && spike |=> (fill_reg == '0))
        else $error("ring not emptied after spike");

endmodule

// File: rtl/asbpt_peak.sv
// windowed maximum and attenuated running peak
// depends on asbpt_pkg
module asbpt_peak
    import asbpt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     step,
    input  logic signed [CODE_W-1:0] sample,
    output logic [PEAK_W-1:0]        peak,
    output logic [PEAK_W-1:0]        peak_next
);

    logic [PEAK_W-1:0] wmax_reg, wmax_next;
    logic [14:0]       wcount_reg, wcount_next;
    logic              seeded_reg, seeded_next;
    logic [PEAK_W-1:0] peak_reg;
    logic [PEAK_W-1:0] blend;

    assign blend = peak_reg - (peak_reg >> cfg.peak_attenuation)
                 + (wmax_reg >> cfg.peak_attenuation);

    always_comb
    begin
        wmax_next   = wmax_reg;
        wcount_next = wcount_reg;
        seeded_next = seeded_reg;
        peak_next   = peak_reg;
        if (step)
        begin
            if (wcount_reg < cfg.peak_window)
            begin
                if (!sample[CODE_W-1] && (sample[PEAK_W-1:0] > wmax_reg))
                begin
                    wmax_next = sample[PEAK_W-1:0];
                end
                wcount_next = wcount_reg + 1'b1;
            end
            else
            begin
                seeded_next = 1'b1;
                peak_next   = seeded_reg ? blend : wmax_reg;
                wmax_next   = '0;
                wcount_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wmax_reg   <= '0;
            wcount_reg <= '0;
            seeded_reg <= 1'b0;
            peak_reg   <= '0;
        end
        else
        begin
            wmax_reg   <= wmax_next;
            wcount_reg <= wcount_next;
            seeded_reg <= seeded_next;
            peak_reg   <= peak_next;
        end
    end

    assign peak = peak_reg;

endmodule

// File: bench/adc_spike_blanker_peak_tracker_tb.sv
`timescale 1ns / 100ps
// testbench for adc_spike_blanker_peak_tracker: directed and random frames over config phases,
// a scoreboard class predicts each result and checks the output stream in order
// depends on asbpt_pkg and the rtl of adc_spike_blanker_peak_tracker
module adc_spike_blanker_peak_tracker_tb;
    import asbpt_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 820;
    localparam int FINAL_ITEMS   = 150;

    typedef struct packed {
        logic [CODE_W-1:0] chan2_code;
        logic [CODE_W-1:0] chan1_code;
        logic [CODE_W-1:0] chan0_code;
    } frame_t;

    typedef struct packed {
        logic [6:0]        pad;
        logic [PEAK_W-1:0] peak_level;
        logic [1:0]        slot_count;
        logic [CODE_W-1:0] slot_c;
        logic [CODE_W-1:0] slot_b;
        logic [CODE_W-1:0] slot_a;
    } result_t;

    class frame_scoreboard;
        cfg_t              regs;
        logic [CODE_W-1:0] ring [RING_DEPTH_DEF];
        int unsigned       head;
        int unsigned       fill;
        int unsigned       holdoff;
        int                win_max;
        int unsigned       win_count;
        bit                seeded;
        logic [PEAK_W-1:0] peak;
        result_t           due_results [$];
        int                errors;

        function new();
            regs      = CFG_RESET;
            head      = 0;
            fill      = 0;
            holdoff   = 0;
            win_max   = 0;
            win_count = 0;
            seeded    = 1'b0;
            peak      = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] reg_index, logic [CFG_DATA_W-1:0] value);
            case (reg_index)
                REG_CHANNEL_MASK:     regs.channel_mask       = value[2:0];
                REG_CAPTURE_ENABLE:   regs.capture_enable     = value[0];
                REG_BLANK_ENABLE:     regs.blank_enable       = value[0];
                REG_SPIKE_SHIFT:      regs.spike_shift        = value[3:0];
                REG_BLANK_LENGTH:     regs.blank_length       = value[15:0];
                REG_PRE_TRIGGER_LEN:  regs.pre_trigger_length = value[5:0];
                REG_PEAK_WINDOW:      regs.peak_window        = value[14:0];
                REG_PEAK_ATTENUATION: regs.peak_attenuation   = value[4:0];
                default: ;
            endcase
        endfunction

        // spike test, hold-off and pre-trigger delay of the first slot
        function bit release_first(input logic [CODE_W-1:0] sample,
                                   output logic [CODE_W-1:0] released);
            int unsigned pre;
            longint      limit;
            pre = regs.pre_trigger_length;
            if (pre > RING_DEPTH_DEF)
                pre = RING_DEPTH_DEF;
            released = sample;
            if (holdoff > 0)
            begin
                holdoff--;
                return 1'b0;
            end
            limit = longint'(peak) << regs.spike_shift;
            if (longint'($signed(sample)) > limit)
            begin
                holdoff = (regs.blank_length > pre + 1) ? regs.blank_length - (pre + 1) : 0;
                fill    = 0;
                return 1'b0;
            end
            if (fill < pre)
            begin
                ring[(head + fill) % RING_DEPTH_DEF] = sample;
                fill++;
                return 1'b0;
            end
            if (fill == 0)
                return 1'b1;
            released   = ring[head];
            ring[head] = sample;
            head       = (head + 1) % RING_DEPTH_DEF;
            return 1'b1;
        endfunction

        function void track_peak(logic [CODE_W-1:0] sample);
            int unsigned a;
            int unsigned m;
            int unsigned nxt;
            if (win_count < regs.peak_window)
            begin
                if (int'($signed(sample)) > win_max)
                    win_max = int'($signed(sample));
                win_count++;
            end
            else
            begin
                a = regs.peak_attenuation;
                m = win_max & 32'h7FFFFF;
                if (!seeded)
                begin
                    seeded = 1'b1;
                    peak   = m[PEAK_W-1:0];
                end
                else
                begin
                    nxt  = peak - (peak >> a) + (m >> a);
                    peak = nxt[PEAK_W-1:0];
                end
                win_max   = 0;
                win_count = 0;
            end
        endfunction

        function void predict_frame(frame_t f);
            logic [CODE_W-1:0] codes [NUM_CHAN];
            logic [CODE_W-1:0] slots [NUM_CHAN];
            logic [CODE_W-1:0] first;
            int                used;
            int                ch;
            result_t           r;
            if (!regs.capture_enable)
                return;
            codes[0] = f.chan0_code;
            codes[1] = f.chan1_code;
            codes[2] = f.chan2_code;
            foreach (slots[i])
                slots[i] = '0;
            used = 0;
            for (ch = 0; ch < NUM_CHAN && ch < CHANNEL_COUNT_DEF; ch++)
            begin
                if (regs.channel_mask[ch])
                begin
                    slots[used] = codes[ch];
                    used++;
                end
            end
            if (used == 0)
                return;
            first = slots[0];
            if (regs.blank_enable && !release_first(slots[0], first))
                return;
            track_peak(first);
            r.pad        = '0;
            r.peak_level = peak;
            r.slot_count = used[1:0];
            r.slot_c     = slots[2];
            r.slot_b     = slots[1];
            r.slot_a     = first;
            due_results.push_back(r);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual %h", $time, got);
                return;
            end
            want = due_results.pop_front();
            compare_field("slot_a", $signed(want.slot_a), $signed(got.slot_a));
            compare_field("slot_b", $signed(want.slot_b), $signed(got.slot_b));
            compare_field("slot_c", $signed(want.slot_c), $signed(got.slot_c));
            compare_field("slot_count", want.slot_count, got.slot_count);
            compare_field("peak_level", want.peak_level, got.peak_level);
            compare_field("padding", want.pad, got.pad);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [71:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [103:0]           m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    frame_scoreboard sb;
    bit              quiet_src;
    bit              quiet_snk;
    int              hold_req;
    int              cycle_count;

    adc_spike_blanker_peak_tracker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("adc_spike_blanker_peak_tracker_tb failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int holds_done;
        holds_done = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != holds_done)
            begin
                holds_done = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= quiet_snk || ($urandom_range(99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.predict_frame(frame_t'(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_result(result_t'(m_tdata));
        end
    end

    task automatic send_frame(input frame_t f);
        while (!quiet_src && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_codes(input logic [CODE_W-1:0] c0, input logic [CODE_W-1:0] c1,
                              input logic [CODE_W-1:0] c2);
        frame_t f;
        f.chan0_code = c0;
        f.chan1_code = c1;
        f.chan2_code = c2;
        send_frame(f);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                           input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(input cfg_t c);
        put_reg(REG_CHANNEL_MASK, CFG_DATA_W'(c.channel_mask));
        put_reg(REG_CAPTURE_ENABLE, CFG_DATA_W'(c.capture_enable));
        put_reg(REG_BLANK_ENABLE, CFG_DATA_W'(c.blank_enable));
        put_reg(REG_SPIKE_SHIFT, CFG_DATA_W'(c.spike_shift));
        put_reg(REG_BLANK_LENGTH, c.blank_length);
        put_reg(REG_PRE_TRIGGER_LEN, CFG_DATA_W'(c.pre_trigger_length));
        put_reg(REG_PEAK_WINDOW, CFG_DATA_W'(c.peak_window));
        put_reg(REG_PEAK_ATTENUATION, CFG_DATA_W'(c.peak_attenuation));
        cfg_valid <= 1'b0;
    endtask

    // drain all expected results, then let dropped frames clear the pipeline
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.channel_mask       = 3'($urandom_range(1, 7));
        c.capture_enable     = 1'b1;
        c.blank_enable       = $urandom_range(99) < 70;
        c.spike_shift        = 4'(($urandom_range(3) == 0) ? $urandom_range(15)
                                                           : $urandom_range(8));
        c.blank_length       = 16'($urandom_range(80));
        c.pre_trigger_length = 6'(($urandom_range(1) == 0) ? $urandom_range(8)
                                                           : $urandom_range(63));
        c.peak_window        = 15'(($urandom_range(99) < 70) ? $urandom_range(16)
                                                             : $urandom_range(300));
        c.peak_attenuation   = 5'(($urandom_range(3) == 0) ? $urandom_range(31)
                                                           : $urandom_range(23));
        return c;
    endfunction

    // mostly quiet signal around zero, some spikes, some full-range codes
    function automatic logic [CODE_W-1:0] pick_code(int unsigned amp_log);
        int v;
        case ($urandom_range(9)) inside
            [0:5]:   v = int'($urandom_range(0, 2 << amp_log)) - (1 << amp_log);
            6:       v = $urandom_range(24'h100000, 24'h7FFFFF);
            default: v = $urandom();
        endcase
        return v[CODE_W-1:0];
    endfunction

    task automatic run_phase(input cfg_t c, input int items);
        int unsigned amp_log;
        frame_t      f;
        write_cfg(c);
        amp_log = $urandom_range(3, 18);
        repeat (items)
        begin
            f.chan0_code = pick_code(amp_log);
            f.chan1_code = pick_code(amp_log);
            f.chan2_code = pick_code(20);
            send_frame(f);
        end
        settle();
    endtask

    initial
    begin : stimulus
        cfg_t c;
        int   phase;
        int   counted;
        int   items;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet_src = 1'b0;
        quiet_snk = 1'b0;
        hold_req  = 0;
        sb        = new();
        rst_n     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // capture is off after reset
        send_codes(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_codes(24'h000000, 24'h000000, 24'h000000);
        settle();

        // all channels, code extremes, window of three closed by an uncounted sample
        c                  = CFG_RESET;
        c.capture_enable   = 1'b1;
        c.channel_mask     = 3'b111;
        c.peak_window      = 15'd3;
        c.peak_attenuation = 5'd0;
        write_cfg(c);
        send_codes(24'd100, 24'hFFFFFF, 24'h800000);
        send_codes(24'hFFFFFB, 24'h000000, 24'h7FFFFF);
        send_codes(24'h800000, 24'h7FFFFF, 24'h000000);
        send_codes(24'h7FFFFF, 24'h800000, 24'hFFFFFF);
        settle();

        c.channel_mask = 3'b000;
        write_cfg(c);
        send_codes(24'h000005, 24'h000006, 24'h000007);
        settle();
        c.channel_mask = 3'b101;
        write_cfg(c);
        send_codes(24'h000001, 24'h123456, 24'hFEDCBA);
        settle();

        // pre-trigger ring of two, spike, short hold-off, zero window
        c.channel_mask       = 3'b011;
        c.blank_enable       = 1'b1;
        c.spike_shift        = 4'd1;
        c.blank_length       = 16'd4;
        c.pre_trigger_length = 6'd2;
        c.peak_window        = 15'd0;
        c.peak_attenuation   = 5'd23;
        write_cfg(c);
        send_codes(24'd10, 24'h000011, 24'h0);
        send_codes(24'd20, 24'h800022, 24'h0);
        send_codes(24'd30, 24'hFF0033, 24'h0);
        send_codes(24'd500, 24'h000044, 24'h0);
        send_codes(24'd40, 24'h7F0055, 24'h0);
        send_codes(24'd50, 24'h000066, 24'h0);
        send_codes(24'd60, 24'h000077, 24'h0);
        send_codes(24'd70, 24'h000088, 24'h0);
        settle();

        // pre-trigger lowered to zero with a filled ring, hold-off saturating at zero
        c.spike_shift        = 4'd0;
        c.blank_length       = 16'd0;
        c.pre_trigger_length = 6'd0;
        write_cfg(c);
        send_codes(24'd80, 24'h000099, 24'h0);
        send_codes(24'd300, 24'h0000AA, 24'h0);
        send_codes(24'hFFFFF9, 24'h0000BB, 24'h0);
        send_codes(24'd90, 24'h0000CC, 24'h0);
        settle();

        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS)
        begin
            c     = random_cfg();
            items = $urandom_range(60, 140);
            case (phase)
                1: c = '{channel_mask:       3'b001,
                         capture_enable:     1'b1,
                         blank_enable:       1'b1,
                         spike_shift:        4'd0,
                         blank_length:       16'd0,
                         pre_trigger_length: 6'd0,
                         peak_window:        15'd0,
                         peak_attenuation:   5'd0};
                2:
                begin
                    // sender streams while the receiver holds off
                    c.blank_enable = 1'b0;
                    quiet_src      = 1'b1;
                    hold_req++;
                end
                3:
                begin
                    c.capture_enable = 1'b0;
                    items            = 20;
                end
                4:
                begin
                    quiet_src = 1'b1;
                    quiet_snk = 1'b1;
                end
                default: ;
            endcase
            run_phase(c, items);
            if (c.capture_enable)
                counted += items;
            quiet_src = 1'b0;
            quiet_snk = 1'b0;
            phase++;
        end

        c = '{channel_mask:       3'b111,
              capture_enable:     1'b1,
              blank_enable:       1'b1,
              spike_shift:        4'd15,
              blank_length:       16'hFFFF,
              pre_trigger_length: 6'd63,
              peak_window:        15'h7FFF,
              peak_attenuation:   5'd31};
        run_phase(c, FINAL_ITEMS);

        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("adc_spike_blanker_peak_tracker_tb passed");
        else
            $display("adc_spike_blanker_peak_tracker_tb failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/asbpt_pkg.sv
rtl/asbpt_cfg.sv
rtl/asbpt_ring.sv
rtl/asbpt_blank.sv
rtl/asbpt_peak.sv
rtl/adc_spike_blanker_peak_tracker.sv
bench/adc_spike_blanker_peak_tracker_tb.sv
